// ----- rtl/core/sip_pkg.sv -----
// ----------------------------------------------------------------------------
// sip_pkg: shared definitions for the saturating int64 power unit
// Widths, limits and the response bundle of the shared multiplier.
// ----------------------------------------------------------------------------
package sip_pkg;

	localparam int unsigned WORD_W = 64;
	localparam int unsigned HALF_W = WORD_W / 2;
	localparam int unsigned EXP_W  = 31;

	// largest positive magnitude and the most negative two's complement word
	localparam logic [WORD_W-1:0] MAX_MAG  = {1'b0, {(WORD_W-1){1'b1}}};
	localparam logic [WORD_W-1:0] SIGN_BIT = {1'b1, {(WORD_W-1){1'b0}}};
	localparam logic [WORD_W-1:0] ONE_WORD = {{(WORD_W-1){1'b0}}, 1'b1};

	// multiplier response: one-cycle done strobe with the overflow verdict
	typedef struct packed {
		logic done;
		logic ovf;
	} sip_mul_rsp_t;

endpackage

// ----- rtl/core/sip_mult.sv -----
// ----------------------------------------------------------------------------
// sip_mult: iterative magnitude multiplier with overflow detect
// Multiplies two non-negative magnitudes below 2^63 over a single 32x32
// multiplier in two passes and flags any product above 2^63-1.
// ----------------------------------------------------------------------------
module sip_mult
	import sip_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WORD_W-1:0] a,
	input  logic [WORD_W-1:0] b,
	output logic [WORD_W-1:0] product,
	output sip_mul_rsp_t      rsp
);

	localparam logic [1:0] MS_IDLE = 2'd0;
	localparam logic [1:0] MS_LO   = 2'd1;
	localparam logic [1:0] MS_HI   = 2'd2;
	localparam logic [1:0] MS_SUM  = 2'd3;

	logic [1:0]          state_q;
	logic [WORD_W-1:0]   x_q;
	logic [HALF_W-1:0]   y_q;
	logic                big_q;
	logic [WORD_W-1:0]   p0_q;
	logic [WORD_W-1:0]   p1_q;
	logic [WORD_W-1:0]   product_q;
	sip_mul_rsp_t        rsp_q;

	logic                a_hi_nz;
	logic                b_hi_nz;
	logic [HALF_W-1:0]   mul_x;
	logic [WORD_W-1:0]   mul_p;
	logic [WORD_W+HALF_W-1:0] sum;

	assign a_hi_nz = |a[WORD_W-1:HALF_W];
	assign b_hi_nz = |b[WORD_W-1:HALF_W];

	// the one shared 32x32 multiplier, low half of x first, then high half
	assign mul_x = (state_q == MS_LO) ? x_q[HALF_W-1:0] : x_q[WORD_W-1:HALF_W];
	assign mul_p = mul_x * y_q;

	// recombine the partial products
	assign sum = {{HALF_W{1'b0}}, p0_q} + {p1_q, {HALF_W{1'b0}}};

	// sequencer for the two passes and the final add
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MS_IDLE;
			rsp_q   <= '0;
		end else begin
			rsp_q.done <= 1'b0;
			unique case (state_q)
				MS_IDLE: begin
					if (start) begin
						// both high halves set means the product is at least 2^64
						big_q <= a_hi_nz & b_hi_nz;
						if (a_hi_nz) begin
							x_q <= a;
							y_q <= b[HALF_W-1:0];
						end else begin
							x_q <= b;
							y_q <= a[HALF_W-1:0];
						end
						state_q <= (a_hi_nz & b_hi_nz) ? MS_SUM : MS_LO;
					end
				end
				MS_LO: begin
					p0_q    <= mul_p;
					state_q <= MS_HI;
				end
				MS_HI: begin
					p1_q    <= mul_p;
					state_q <= MS_SUM;
				end
				MS_SUM: begin
					product_q  <= sum[WORD_W-1:0];
					rsp_q.done <= 1'b1;
					rsp_q.ovf  <= big_q | (|sum[WORD_W+HALF_W-1:WORD_W-1]);
					state_q    <= MS_IDLE;
				end
				default: state_q <= MS_IDLE;
			endcase
		end
	end

	assign product = product_q;
	assign rsp     = rsp_q;

endmodule

// ----- rtl/core/saturating_int64_power_unit.sv -----
// ----------------------------------------------------------------------------
// saturating_int64_power_unit: signed 64-bit power with saturation
// Square-and-multiply on the base magnitude with a shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   A transfer is taken at a rising edge with start high and busy low; it
//   carries base_value and exponent. busy stays high while the item is
//   worked on. The result appears on power_value and overflowed for exactly
//   one cycle with done high; the receiver cannot stall it.
// Sequence:
//   zero base, zero exponent or a base of -2^63 give the result in the
//   cycle after the transfer. Otherwise the unit walks the exponent from
//   its lowest bit up to the highest set bit: for a set bit it decides,
//   multiplies into the running product on the shared multiplier, shifts
//   and squares; for a clear bit it decides, shifts and squares, and the
//   lowest set bit skips its multiply. The top bit needs no squaring;
//   saturation ends the walk early.
// Throughput:
//   one item at a time; a new transfer may start in the cycle done is high.
// Reset:
//   arst_n clears the sequencer and the done strobe; no result is pending.
// ----------------------------------------------------------------------------
module saturating_int64_power_unit
	import sip_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [WORD_W-1:0] base_value,
	input  logic        [EXP_W-1:0]  exponent,
	output logic                     done,
	output logic signed [WORD_W-1:0] power_value,
	output logic                     overflowed
);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_ROUND    = 3'd1;
	localparam logic [2:0] ST_WAIT_ACC = 3'd2;
	localparam logic [2:0] ST_STEP     = 3'd3;
	localparam logic [2:0] ST_WAIT_SQR = 3'd4;

	logic [2:0]        state_q;
	logic [WORD_W-1:0] mag_q;
	logic [WORD_W-1:0] acc_q;
	logic [EXP_W-1:0]  e_q;
	logic              neg_q;
	logic              done_q;
	logic [WORD_W-1:0] power_q;
	logic              ovf_q;

	logic [WORD_W-1:0] raw;
	logic [WORD_W-1:0] base_mag;
	logic              mul_start;
	logic [WORD_W-1:0] mul_a;
	logic [WORD_W-1:0] mul_b;
	logic [WORD_W-1:0] mul_product;
	sip_mul_rsp_t      mul_rsp;
	logic              last_bit;

	assign raw      = base_value;
	assign base_mag = raw[WORD_W-1] ? (~raw + ONE_WORD) : raw;
	assign last_bit = (e_q[EXP_W-1:1] == '0);

	// launch the shared multiplier: accumulate in a round, square in a step
	always_comb begin
		mul_start = 1'b0;
		mul_a     = acc_q;
		mul_b     = mag_q;
		if (state_q == ST_ROUND && e_q[0] && acc_q != ONE_WORD) begin
			mul_start = 1'b1;
		end else if (state_q == ST_STEP && !last_bit) begin
			mul_start = 1'b1;
			mul_a     = mag_q;
		end
	end

	sip_mult u_mult (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.product (mul_product),
		.rsp     (mul_rsp)
	);

	// sequencer over the exponent bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (raw == '0) begin
							done_q  <= 1'b1;
							power_q <= (exponent == '0) ? ONE_WORD : '0;
							ovf_q   <= 1'b0;
						end else if (exponent == '0) begin
							done_q  <= 1'b1;
							power_q <= ONE_WORD;
							ovf_q   <= 1'b0;
						end else if (raw == SIGN_BIT) begin
							done_q  <= 1'b1;
							power_q <= MAX_MAG;
							ovf_q   <= 1'b1;
						end else begin
							mag_q   <= base_mag;
							acc_q   <= ONE_WORD;
							e_q     <= exponent;
							neg_q   <= raw[WORD_W-1] & exponent[0];
							state_q <= ST_ROUND;
						end
					end
				end
				ST_ROUND: begin
					if (!e_q[0]) begin
						state_q <= ST_STEP;
					end else if (acc_q == ONE_WORD) begin
						// product of one and the magnitude needs no multiply
						acc_q   <= mag_q;
						state_q <= ST_STEP;
					end else begin
						state_q <= ST_WAIT_ACC;
					end
				end
				ST_WAIT_ACC: begin
					if (mul_rsp.done) begin
						if (mul_rsp.ovf) begin
							done_q  <= 1'b1;
							power_q <= MAX_MAG;
							ovf_q   <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							acc_q   <= mul_product;
							state_q <= ST_STEP;
						end
					end
				end
				ST_STEP: begin
					e_q <= e_q >> 1;
					if (last_bit) begin
						done_q  <= 1'b1;
						power_q <= neg_q ? (~acc_q + ONE_WORD) : acc_q;
						ovf_q   <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_WAIT_SQR;
					end
				end
				ST_WAIT_SQR: begin
					if (mul_rsp.done) begin
						if (mul_rsp.ovf) begin
							done_q  <= 1'b1;
							power_q <= MAX_MAG;
							ovf_q   <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							mag_q   <= mul_product;
							state_q <= ST_ROUND;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign power_value = power_q;
	assign overflowed  = ovf_q;

endmodule

// ----- rtl/core/sip_checker.sv -----
// ----------------------------------------------------------------------------
// sip_checker: port-level checks for the saturating int64 power unit
// Watches the command and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module sip_checker
	import sip_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     start,
	input logic                     busy,
	input logic signed [WORD_W-1:0] base_value,
	input logic        [EXP_W-1:0]  exponent,
	input logic                     done,
	input logic signed [WORD_W-1:0] power_value,
	input logic                     overflowed
);

	// a result is only shown once the unit has gone idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// saturation always gives the largest positive value
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		done && overflowed |-> power_value == MAX_MAG)
		else $error("overflow without saturated value");

	// zero exponent answers one in the next cycle
	a_zero_exp: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && exponent == '0 |=> done && !overflowed && power_value == 1)
		else $error("zero exponent did not give one");

	// zero base answers in the next cycle without overflow
	a_zero_base: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && base_value == '0 |=> done && !overflowed)
		else $error("zero base not answered at once");

	// a transfer that makes the unit busy gives no result in that first cycle
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		busy && !$past(busy) |-> !done)
		else $error("result on the cycle busy rose");

endmodule

bind saturating_int64_power_unit sip_checker u_sip_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.base_value  (base_value),
	.exponent    (exponent),
	.done        (done),
	.power_value (power_value),
	.overflowed  (overflowed)
);
